@@ design/assert_macros.svh @@
// Assertion macros for the design files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low
`define CHK_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low
`define CHK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/sfrfd_pkg.sv @@
// Shared types and constants for the sensor frame receiver and float decoder.
`default_nettype none

package sfrfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FLEN_W  = 5;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned HUND_W  = 8;
  localparam int unsigned SIG_W   = 24;
  localparam int unsigned SH_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH  = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST  = 5'd14;

  // Frame layout: payload word sits in bytes 8..11
  localparam int unsigned WORD_BYTE_LO = 8;
  localparam int unsigned WORD_BYTES   = 4;

  // Single-precision decode constants
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0]  EXP_INT      = 8'd150;  // exponent where the LSB weighs 1
  localparam logic [7:0]  EXP_SAT      = 8'd158;  // first exponent at 2^31
  localparam logic [7:0]  SH_ZERO_HUND = 8'd31;   // right shift where hundredths vanish
  localparam logic [SIG_W-1:0] SIG_HIDDEN_ONLY = 24'h800000;
  localparam logic [WORD_W-1:0] WHOLE_POS_SAT = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] WHOLE_NEG_SAT = 32'h80000000;
  localparam logic [6:0]  HUND_SCALE   = 7'd100;

  // Unpacked value between the unpack and scale stages
  typedef struct packed {
    logic              neg;
    logic              bad;
    logic [WORD_W-1:0] whole;
    logic [SIG_W-1:0]  frac;
    logic [SH_W-1:0]   sh;
    logic [WORD_W-1:0] raw;
  } sfrfd_unpk_t;

endpackage

`default_nettype wire

@@ design/sensor_frame_receiver_float_decode.sv @@
// Top level: sensor frame receiver with exact single-precision decode.
//
//  channel | dir | handshake              | words
//  --------+-----+------------------------+--------------------------------------------
//  in_     | in  | in_valid / in_stall    | in_rx_byte, one serial byte per word
//  out_    | out | out_valid / out_stall  | whole_part, hundredths, raw_bits, invalid
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (header, header, length)
//
// One input word per cycle while in_stall is low. A completed frame's result
// passes through the frame word register, unpack register and result register.
// Reset loads the default headers and length, empties the fill count and the
// pipeline; no clearing pass, cfg_ready is always high.
// out_stall backs up through the three registers; in_stall rises only when
// all three hold a result and out_stall is high.
`default_nettype none
`include "assert_macros.svh"

module sensor_frame_receiver_float_decode import sfrfd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [BYTE_W-1:0]      in_rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [WORD_W-1:0]    out_whole_part,
  output logic signed [HUND_W-1:0]    out_hundredths,
  output logic        [WORD_W-1:0]    out_raw_bits,
  output logic                        out_invalid
);

  logic              wd_valid, wd_stall;
  logic [WORD_W-1:0] wd_bits;
  logic              up_valid, up_stall;
  sfrfd_unpk_t       up_data;

  assign cfg_ready = 1'b1;

  // Framing and word capture
  sfrfd_frame #(.STORE_DEPTH(STORE_DEPTH)) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .wd_valid   (wd_valid),
    .wd_stall   (wd_stall),
    .wd_bits    (wd_bits)
  );

  // Float unpack and integer part
  sfrfd_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .wd_valid (wd_valid),
    .wd_stall (wd_stall),
    .wd_bits  (wd_bits),
    .up_valid (up_valid),
    .up_stall (up_stall),
    .up_data  (up_data)
  );

  // Hundredths and result register
  sfrfd_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (up_valid),
    .up_stall       (up_stall),
    .up_data        (up_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_whole_part (out_whole_part),
    .out_hundredths (out_hundredths),
    .out_raw_bits   (out_raw_bits),
    .out_invalid    (out_invalid)
  );

  // Checks
  `CHK_SAME(a_bad_no_hund, out_valid && out_invalid, out_hundredths == 8'sd0, "invalid word with nonzero hundredths")
  `CHK_SAME(a_hund_range, out_valid, out_hundredths >= -8'sd99 && out_hundredths <= 8'sd99, "hundredths out of range")
  `CHK_SAME(a_stall_chain, in_stall, out_valid && out_stall, "input stalled while output drains")
  `CHK_SAME(a_subnorm_whole, out_valid && out_raw_bits[30:23] == 8'd0, out_whole_part == 32'sd0 && !out_invalid, "subnormal with integer part")

endmodule

`default_nettype wire

@@ design/sfrfd_frame.sv @@
// Framing stage: header check, fill count, payload byte capture and word register.
`default_nettype none

module sfrfd_frame import sfrfd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_rx_byte,
  output logic                      wd_valid,
  input  wire logic                 wd_stall,
  output logic [WORD_W-1:0]         wd_bits
);

  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > FLEN_W) ? CW : FLEN_W;

  logic [BYTE_W-1:0] fh_r, sh_r;
  logic [FLEN_W-1:0] flen_r;
  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_inc;
  logic [BYTE_W-1:0] st0_r, st0_nxt, st1_r, st1_nxt;
  logic [BYTE_W-1:0] hi_r [WORD_BYTES];
  logic [BYTE_W-1:0] hi_nxt [WORD_BYTES];
  logic              done;
  logic              accept;
  logic              wd_valid_r;
  logic [WORD_W-1:0] wd_bits_r;

  assign in_stall = wd_valid_r && wd_stall;
  assign accept   = in_valid && !in_stall;
  assign wd_valid = wd_valid_r;
  assign wd_bits  = wd_bits_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fh_r   <= FIRST_HEADER_RST;
      sh_r   <= SECOND_HEADER_RST;
      flen_r <= FRAME_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_HEADER:  fh_r   <= cfg_data;
        CFG_SECOND_HEADER: sh_r   <= cfg_data;
        CFG_FRAME_LENGTH:  flen_r <= cfg_data[FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Store the byte, then check the header and the length, resync, wrap at STORE_DEPTH
  always_comb begin
    st0_nxt = st0_r;
    st1_nxt = st1_r;
    for (int i = 0; i < WORD_BYTES; i++) hi_nxt[i] = hi_r[i];
    done    = 1'b0;
    cnt_inc = cnt_r + 1'b1;

    if (cnt_r == CW'(0)) st0_nxt = in_rx_byte;
    if (cnt_r == CW'(1)) st1_nxt = in_rx_byte;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (cnt_r == CW'(WORD_BYTE_LO + i)) hi_nxt[i] = in_rx_byte;
    end

    cnt_nxt = cnt_inc;
    if (cnt_inc >= CW'(2)) begin
      if (st0_nxt == fh_r && st1_nxt == sh_r) begin
        if (CMPW'(cnt_inc) == CMPW'(flen_r)) begin
          done    = 1'b1;
          cnt_nxt = '0;
        end
      end else if (in_rx_byte == fh_r) begin
        // resync on a fresh first-header byte
        st0_nxt = fh_r;
        cnt_nxt = CW'(1);
      end
    end
    if (cnt_nxt >= CW'(STORE_DEPTH)) cnt_nxt = '0;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st0_r <= st0_nxt;
      st1_r <= st1_nxt;
      for (int i = 0; i < WORD_BYTES; i++) hi_r[i] <= hi_nxt[i];
    end
  end

  // Completed frame word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_valid_r <= 1'b0;
    end else if (accept) begin
      wd_valid_r <= done;
    end else if (!wd_stall) begin
      wd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      wd_bits_r <= {hi_nxt[3], hi_nxt[2], hi_nxt[1], hi_nxt[0]};
    end
  end

endmodule

`default_nettype wire

@@ design/sfrfd_unpack.sv @@
// Unpack stage: splits the single, handles specials and saturation, integer part.
`default_nettype none

module sfrfd_unpack import sfrfd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wd_valid,
  output logic                   wd_stall,
  input  wire logic [WORD_W-1:0] wd_bits,
  output logic                   up_valid,
  input  wire logic              up_stall,
  output sfrfd_unpk_t            up_data
);

  logic              up_valid_r;
  sfrfd_unpk_t       up_data_r, up_nxt;
  logic              accept;
  logic [7:0]        expo, ex, shv;
  logic [22:0]       mant;
  logic [SIG_W-1:0]  sig;
  logic [2:0]        lsh;
  logic [WORD_W-1:0] mag;

  assign wd_stall = up_valid_r && up_stall;
  assign accept   = wd_valid && !wd_stall;
  assign up_valid = up_valid_r;
  assign up_data  = up_data_r;

  assign expo = wd_bits[30:23];
  assign mant = wd_bits[22:0];
  assign ex   = (expo == 8'd0) ? 8'd1 : expo;
  assign sig  = {(expo != 8'd0), mant};
  assign shv  = EXP_INT - ex;
  assign lsh  = 3'(ex - EXP_INT);

  // Classify and split into integer and fraction
  always_comb begin
    up_nxt.neg   = wd_bits[31];
    up_nxt.bad   = 1'b0;
    up_nxt.whole = '0;
    up_nxt.frac  = '0;
    up_nxt.sh    = '0;
    up_nxt.raw   = wd_bits;
    mag          = '0;

    if (expo == EXP_ALL_ONES) begin
      // NaN reads zero, infinity saturates
      up_nxt.bad = 1'b1;
      if (mant == 23'd0) up_nxt.whole = wd_bits[31] ? WHOLE_NEG_SAT : WHOLE_POS_SAT;
    end else if (ex >= EXP_SAT) begin
      if (wd_bits[31] && ex == EXP_SAT && sig == SIG_HIDDEN_ONLY) begin
        up_nxt.whole = WHOLE_NEG_SAT;
      end else begin
        up_nxt.bad   = 1'b1;
        up_nxt.whole = wd_bits[31] ? WHOLE_NEG_SAT : WHOLE_POS_SAT;
      end
    end else if (ex >= EXP_INT) begin
      mag          = {8'd0, sig} << lsh;
      up_nxt.whole = wd_bits[31] ? (~mag + 1'b1) : mag;
    end else if (shv < SH_ZERO_HUND) begin
      mag          = {8'd0, sig} >> shv[SH_W-1:0];
      up_nxt.whole = wd_bits[31] ? (~mag + 1'b1) : mag;
      up_nxt.frac  = sig & ~({SIG_W{1'b1}} << shv[SH_W-1:0]);
      up_nxt.sh    = shv[SH_W-1:0];
    end
    // tiny magnitudes leave the whole, fraction and shift zero
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_valid_r <= 1'b0;
    end else if (accept) begin
      up_valid_r <= 1'b1;
    end else if (!up_stall) begin
      up_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) up_data_r <= up_nxt;
  end

endmodule

`default_nettype wire

@@ design/sfrfd_scale.sv @@
// Scale stage: fraction times 100, truncated, signed, into the result register.
`default_nettype none

module sfrfd_scale import sfrfd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     up_valid,
  output logic                          up_stall,
  input  wire sfrfd_unpk_t              up_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [WORD_W-1:0]      out_whole_part,
  output logic signed [HUND_W-1:0]      out_hundredths,
  output logic        [WORD_W-1:0]      out_raw_bits,
  output logic                          out_invalid
);

  localparam int unsigned PROD_W = SIG_W + 7;

  logic              out_valid_r;
  logic [WORD_W-1:0] whole_r, raw_r;
  logic [HUND_W-1:0] hund_r, hund_nxt;
  logic              bad_r;
  logic [PROD_W-1:0] prod, prod_sh;
  logic [6:0]        h;
  logic              accept;

  assign up_stall = out_valid_r && out_stall;
  assign accept   = up_valid && !up_stall;

  // Exact hundredths: (frac * 100) >> sh
  assign prod     = {7'd0, up_data.frac} * {{(PROD_W-7){1'b0}}, HUND_SCALE};
  assign prod_sh  = prod >> up_data.sh;
  assign h        = prod_sh[6:0];
  assign hund_nxt = up_data.neg ? (~{1'b0, h} + 1'b1) : {1'b0, h};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      whole_r <= up_data.whole;
      hund_r  <= hund_nxt;
      raw_r   <= up_data.raw;
      bad_r   <= up_data.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_whole_part = $signed(whole_r);
  assign out_hundredths = $signed(hund_r);
  assign out_raw_bits   = raw_r;
  assign out_invalid    = bad_r;

endmodule

`default_nettype wire
